// File: design/udpd_pkg.sv
// udpd_pkg: shared types and constants for the UDP port demultiplexer.
// Used by udpd_front, udpd_queue, udpd_back and udp_port_demux.
`default_nettype none

package udpd_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_LISTEN = 2'd0,
        CMD_CLOSE  = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_t;

    // Final datagram status codes
    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_NOLISTEN  = 2'd3
    } status_t;

    // UDP header byte positions
    localparam logic [15:0] IDX_SRC_HI = 16'd0;
    localparam logic [15:0] IDX_SRC_LO = 16'd1;
    localparam logic [15:0] IDX_DST_HI = 16'd2;
    localparam logic [15:0] IDX_DST_LO = 16'd3;
    localparam logic [15:0] IDX_LEN_HI = 16'd4;
    localparam logic [15:0] IDX_LEN_LO = 16'd5;
    localparam logic [15:0] IDX_HDR_END = 16'd7;
    localparam logic [15:0] HDR_BYTES = 16'd8;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Result queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_AW = 1;

    // One result word
    typedef struct packed {
        logic [1:0]  slot;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        done_res;
        status_t     status;
        logic [15:0] payload_length;
    } res_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: design/udpd_front.sv
// udpd_front: listener table, header parser and result builder.
// Depends on udpd_pkg; pushes result words into udpd_queue.
`default_nettype none

module udpd_front #(
    parameter int SLOTS = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic [1:0]      in_command,
    input  wire logic [15:0]     in_port,
    input  wire logic [7:0]      in_data_byte,
    input  wire logic            in_last,
    input  wire logic [31:0]     in_source_ip,
    input  udpd_pkg::q_stat_t    q_stat,
    output logic                 push,
    output udpd_pkg::res_t       push_data
);
    import udpd_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             accept;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [15:0]      sport_reg [SLOTS];
    logic             tbl_wr;
    logic [SW-1:0]    tbl_wr_idx;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [15:0]      len_reg, len_next;
    logic [31:0]      ip_reg, ip_next;
    logic             mf_reg, mf_next, mf_cur;
    logic [SW-1:0]    ms_reg, ms_next, ms_cur;
    logic             hit, free_found, dm_found;
    logic [SW-1:0]    free_idx, dm_idx;
    logic             is_data, fwd;
    logic [16:0]      received;
    logic [SW+1:0]    slot_ext;
    status_t          st;

    assign accept  = in_valid && !q_stat.full;
    assign is_data = accept && (in_command == CMD_DATA);

    // Table search: existing port, first free slot, header destination match
    always_comb begin
        hit = 1'b0;
        free_found = 1'b0;
        free_idx = '0;
        dm_found = 1'b0;
        dm_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (used_reg[i] && sport_reg[i] == in_port) begin
                hit = 1'b1;
            end
            if (!used_reg[i] && !free_found) begin
                free_found = 1'b1;
                free_idx = SW'(i);
            end
            if (used_reg[i] && sport_reg[i] == dst_reg && !dm_found) begin
                dm_found = 1'b1;
                dm_idx = SW'(i);
            end
        end
    end

    // Listen / close table update
    always_comb begin
        used_next = used_reg;
        tbl_wr = 1'b0;
        tbl_wr_idx = free_idx;
        if (accept) begin
            unique case (in_command)
                CMD_LISTEN: begin
                    if (!hit && free_found) begin
                        used_next[free_idx] = 1'b1;
                        tbl_wr = 1'b1;
                    end
                end
                CMD_CLOSE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used_reg[i] && sport_reg[i] == in_port) begin
                            used_next[i] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Header parse for the current byte
    always_comb begin
        ip_next  = ip_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        len_next = len_reg;
        mf_cur   = mf_reg;
        ms_cur   = ms_reg;
        if (count_reg == IDX_SRC_HI) begin
            ip_next  = in_source_ip;
            src_next = {in_data_byte, 8'h00};
            dst_next = '0;
            len_next = '0;
            mf_cur   = 1'b0;
            ms_cur   = '0;
        end
        if (count_reg == IDX_SRC_LO) src_next = {src_reg[15:8], in_data_byte};
        if (count_reg == IDX_DST_HI) dst_next = {in_data_byte, 8'h00};
        if (count_reg == IDX_DST_LO) dst_next = {dst_reg[15:8], in_data_byte};
        if (count_reg == IDX_LEN_HI) len_next = {in_data_byte, 8'h00};
        if (count_reg == IDX_LEN_LO) len_next = {len_reg[15:8], in_data_byte};
        if (count_reg == IDX_HDR_END) begin
            mf_cur = dm_found;
            ms_cur = dm_idx;
        end
    end

    // Forward decision and final status
    assign fwd      = mf_cur && (count_reg >= HDR_BYTES) && (count_reg < len_next);
    assign received = {1'b0, count_reg} + 17'd1;

    always_comb begin
        priority if (received < {1'b0, HDR_BYTES}) begin
            st = ST_SHORT;
        end else if ({1'b0, len_next} > received) begin
            st = ST_TRUNC;
        end else if (len_next < HDR_BYTES) begin
            st = ST_SHORT;
        end else if (!mf_cur) begin
            st = ST_NOLISTEN;
        end else begin
            st = ST_DELIVERED;
        end
    end

    // Build the result word
    assign slot_ext = {2'b00, ms_cur};

    always_comb begin
        push_data.slot         = mf_cur ? slot_ext[1:0] : 2'b00;
        push_data.sender_ip    = ip_next;
        push_data.sender_port  = src_next;
        push_data.payload_byte = fwd ? in_data_byte : 8'h00;
        push_data.byte_valid   = fwd;
        push_data.done_res     = in_last;
        push_data.status       = in_last ? st : ST_DELIVERED;
        push_data.payload_length =
            (count_reg >= IDX_HDR_END && len_next >= HDR_BYTES) ? (len_next - HDR_BYTES)
                                                                : 16'h0000;
    end

    assign push = is_data && (fwd || in_last);

    // Byte counter and match state
    always_comb begin
        count_next = count_reg;
        mf_next    = mf_reg;
        ms_next    = ms_reg;
        if (is_data) begin
            ms_next = ms_cur;
            if (in_last) begin
                count_next = '0;
                mf_next    = 1'b0;
            end else begin
                mf_next = mf_cur;
                if (count_reg != COUNT_MAX) count_next = count_reg + 16'd1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            count_reg <= '0;
            mf_reg    <= 1'b0;
            ms_reg    <= '0;
        end else begin
            used_reg  <= used_next;
            count_reg <= count_next;
            mf_reg    <= mf_next;
            ms_reg    <= ms_next;
        end
    end

    // Header and table payload registers
    always_ff @(posedge aclk) begin
        if (is_data) begin
            ip_reg  <= ip_next;
            src_reg <= src_next;
            dst_reg <= dst_next;
            len_reg <= len_next;
        end
        if (tbl_wr) begin
            sport_reg[tbl_wr_idx] <= in_port;
        end
    end

endmodule

`default_nettype wire

// File: design/udpd_queue.sv
// udpd_queue: two-word result queue between the front and back stages.
// Depends on udpd_pkg for the result word type.
`default_nettype none

module udpd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  udpd_pkg::res_t     push_data,
    input  wire logic          pop,
    output udpd_pkg::res_t     pop_data,
    output udpd_pkg::q_stat_t  q_stat
);
    import udpd_pkg::*;

    res_t                mem [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]       cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    // Pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: design/udpd_back.sv
// udpd_back: output register that drains the result queue to the m_ channel.
// Depends on udpd_pkg for the result word type.
`default_nettype none

module udpd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  udpd_pkg::q_stat_t  q_stat,
    input  udpd_pkg::res_t     q_data,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output udpd_pkg::res_t     out_data
);
    import udpd_pkg::*;

    logic valid_reg;
    res_t data_reg;

    // Load a new word when the register is empty or being taken
    assign pop       = !q_stat.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) data_reg <= q_data;
    end

endmodule

`default_nettype wire

// File: design/udp_port_demux.sv
// udp_port_demux: UDP listener table and streaming receive demultiplexer.
// A data word that forwards a byte or ends a datagram is written into the queue at its
// accepting edge and moves to the output register once that register is empty or taken.
// Throughput: one input word per cycle; the listener compare across all slots
// and the header parse finish in the accepting cycle, a two-word queue follows;
// s_ready drops only while the queue holds two words behind a stalled output.
// Reset (synchronous, aresetn low) empties the listener table, the byte counter
// and the queue; no clearing pass is needed.
`default_nettype none

module udp_port_demux #(
    parameter int LISTENER_SLOTS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_port,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last,
    input  wire logic [31:0] s_source_ip,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_slot,
    output logic [31:0]      m_sender_ip,
    output logic [15:0]      m_sender_port,
    output logic [7:0]       m_payload_byte,
    output logic             m_byte_valid,
    output logic             m_done_res,
    output logic [1:0]       m_status,
    output logic [15:0]      m_payload_length
);
    import udpd_pkg::*;

    q_stat_t q_stat;
    res_t    push_data, pop_data, out_data;
    logic    push, pop;

    assign s_ready = !q_stat.full;

    udpd_front #(
        .SLOTS(LISTENER_SLOTS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_command   (s_command),
        .in_port      (s_port),
        .in_data_byte (s_data_byte),
        .in_last      (s_last),
        .in_source_ip (s_source_ip),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    udpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    udpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // Unpack the result word onto the m_ ports
    assign m_slot           = out_data.slot;
    assign m_sender_ip      = out_data.sender_ip;
    assign m_sender_port    = out_data.sender_port;
    assign m_payload_byte   = out_data.payload_byte;
    assign m_byte_valid     = out_data.byte_valid;
    assign m_done_res       = out_data.done_res;
    assign m_status         = out_data.status;
    assign m_payload_length = out_data.payload_length;

`ifndef SYNTHESIS
    // A full queue always has a word parked in the output register
    a_full_has_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("queue full while output register empty");

    // Non-forwarded words carry a zero byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_payload_byte == 8'h00))
        else $error("payload byte set without byte_valid");

    // Status only on the final word
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_status == ST_DELIVERED))
        else $error("status set on a non-final word");

    // A forwarded byte implies a nonempty payload
    a_fwd_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_valid) |-> (m_payload_length != 16'h0000))
        else $error("forwarded byte with zero payload length");
`endif

endmodule

`default_nettype wire
